FILE: sv/arcm_pkg.sv
// ----------------------------------------------------------------------------
// arcm_pkg
// Shared types, mode codes and color tables for the auto-ranging false-color
// mapper.
// ----------------------------------------------------------------------------
package arcm_pkg;

  localparam int unsigned T_FRAC_BITS_DEF = 10;

  localparam int unsigned VAL_W    = 24;
  localparam int unsigned PAL_SIZE = 24;

  localparam logic [1:0] MODE_HEIGHT    = 2'd0;
  localparam logic [1:0] MODE_TREE      = 2'd1;
  localparam logic [1:0] MODE_LABEL     = 2'd2;
  localparam logic [1:0] MODE_INTENSITY = 2'd3;

  localparam logic REQ_SCAN  = 1'b0;
  localparam logic REQ_COLOR = 1'b1;

  localparam logic [7:0] CLS_NEVER     = 8'd0;
  localparam logic [7:0] CLS_GROUND    = 8'd2;
  localparam logic [7:0] CLS_LOW_VEG   = 8'd3;
  localparam logic [7:0] CLS_MED_VEG   = 8'd4;
  localparam logic [7:0] CLS_HIGH_VEG  = 8'd5;
  localparam logic [7:0] CLS_BUILDING  = 8'd6;
  localparam logic [7:0] CLS_WATER     = 8'd9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  localparam rgb_t PALETTE [PAL_SIZE] = '{
    '{red: 8'd255, green: 8'd0,   blue: 8'd0},
    '{red: 8'd0,   green: 8'd255, blue: 8'd0},
    '{red: 8'd0,   green: 8'd0,   blue: 8'd255},
    '{red: 8'd255, green: 8'd255, blue: 8'd0},
    '{red: 8'd255, green: 8'd0,   blue: 8'd255},
    '{red: 8'd0,   green: 8'd255, blue: 8'd255},
    '{red: 8'd255, green: 8'd128, blue: 8'd0},
    '{red: 8'd128, green: 8'd0,   blue: 8'd255},
    '{red: 8'd255, green: 8'd0,   blue: 8'd128},
    '{red: 8'd0,   green: 8'd255, blue: 8'd128},
    '{red: 8'd128, green: 8'd255, blue: 8'd0},
    '{red: 8'd0,   green: 8'd128, blue: 8'd255},
    '{red: 8'd255, green: 8'd128, blue: 8'd128},
    '{red: 8'd128, green: 8'd255, blue: 8'd128},
    '{red: 8'd128, green: 8'd128, blue: 8'd255},
    '{red: 8'd255, green: 8'd255, blue: 8'd128},
    '{red: 8'd255, green: 8'd128, blue: 8'd255},
    '{red: 8'd128, green: 8'd255, blue: 8'd255},
    '{red: 8'd192, green: 8'd64,  blue: 8'd64},
    '{red: 8'd64,  green: 8'd192, blue: 8'd64},
    '{red: 8'd64,  green: 8'd64,  blue: 8'd192},
    '{red: 8'd192, green: 8'd192, blue: 8'd64},
    '{red: 8'd192, green: 8'd64,  blue: 8'd192},
    '{red: 8'd64,  green: 8'd192, blue: 8'd192}
  };

  function automatic rgb_t label_color(input logic [7:0] lab);
    rgb_t c;
    case (lab)
      CLS_NEVER:    c = '{red: 8'd128, green: 8'd128, blue: 8'd128};
      CLS_GROUND:   c = '{red: 8'd139, green: 8'd69,  blue: 8'd19};
      CLS_LOW_VEG:  c = '{red: 8'd144, green: 8'd238, blue: 8'd144};
      CLS_MED_VEG:  c = '{red: 8'd34,  green: 8'd139, blue: 8'd34};
      CLS_HIGH_VEG: c = '{red: 8'd0,   green: 8'd100, blue: 8'd0};
      CLS_BUILDING: c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
      CLS_WATER:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
      default:      c = '{red: 8'd200, green: 8'd200, blue: 8'd200};
    endcase
    return c;
  endfunction

  // palette index of a non-negative 15-bit id: 8 * ((id >> 3) mod 3) + id[2:0]
  function automatic logic [4:0] tree_index(input logic [14:0] id);
    logic [4:0] s;
    logic [1:0] m3;
    s = 5'd0;
    for (int i = 0; i < 6; i++) begin
      s = s + {3'b000, id[3 + 2 * i +: 2]};
    end
    if (s >= 5'd9) begin
      s = s - 5'd9;
    end
    if (s >= 5'd6) begin
      s = s - 5'd6;
    end
    if (s >= 5'd3) begin
      s = s - 5'd3;
    end
    m3 = s[1:0];
    return {m3, id[2:0]};
  endfunction

endpackage

FILE: sv/arcm_div.sv
// ----------------------------------------------------------------------------
// arcm_div
// Restoring divider, one quotient bit per cycle: q = floor(d * 2^T / r)
// for 0 < d < r.
// ----------------------------------------------------------------------------
module arcm_div #(
  parameter int unsigned T_FRAC_BITS = arcm_pkg::T_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [arcm_pkg::VAL_W-1:0]     dividend_i,
  input  logic [arcm_pkg::VAL_W-1:0]     divisor_i,
  output logic                           done_o,
  output logic [T_FRAC_BITS-1:0]         quotient_o
);

  localparam int unsigned W     = arcm_pkg::VAL_W;
  localparam int unsigned CNT_W = $clog2(T_FRAC_BITS + 1);

  logic [W-1:0]           rem_q, rem_d;
  logic [W-1:0]           div_q, div_d;
  logic [T_FRAC_BITS-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  logic [W:0] shifted;
  logic [W:0] diff;
  logic       ge;

  assign shifted = {rem_q, 1'b0};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = shifted >= {1'b0, div_q};

  always_comb begin
    rem_d = rem_q;
    div_d = div_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = dividend_i;
      div_d = divisor_i;
      quo_d = '0;
      cnt_d = CNT_W'(T_FRAC_BITS);
    end else if (cnt_q != '0) begin
      rem_d = ge ? diff[W-1:0] : shifted[W-1:0];
      quo_d = {quo_q[T_FRAC_BITS-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  assign done_o     = (cnt_q == CNT_W'(1));
  assign quotient_o = {quo_q[T_FRAC_BITS-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

endmodule

FILE: sv/arcm_color.sv
// ----------------------------------------------------------------------------
// arcm_color
// Maps a fraction, tree id or class label to an 8-bit rgb triple for the
// selected color mode.
// ----------------------------------------------------------------------------
module arcm_color #(
  parameter int unsigned T_FRAC_BITS = arcm_pkg::T_FRAC_BITS_DEF
) (
  input  logic [1:0]             mode_i,
  input  logic [T_FRAC_BITS:0]   frac_i,
  input  logic [15:0]            tree_id_i,
  input  logic [7:0]             class_label_i,
  output arcm_pkg::rgb_t         rgb_o
);

  localparam int unsigned SEG_W = T_FRAC_BITS - 2;
  localparam int unsigned X_W   = T_FRAC_BITS - 1;
  localparam int unsigned PR_W  = X_W + 8;
  localparam int unsigned GR_W  = T_FRAC_BITS + 9;
  localparam logic [X_W-1:0] QUARTER = X_W'(1) << SEG_W;

  logic [SEG_W-1:0] lower;
  logic [1:0]       seg;
  logic [X_W-1:0]   x_up, x_down;
  logic [PR_W-1:0]  p_up, p_down;
  logic [7:0]       lvl_up, lvl_down;
  logic [GR_W-1:0]  p_grey;
  logic [7:0]       grey;
  logic [4:0]       pal_idx;
  arcm_pkg::rgb_t   ramp;

  assign lower  = frac_i[SEG_W-1:0];
  assign seg    = frac_i[T_FRAC_BITS-1:T_FRAC_BITS-2];
  assign x_up   = {1'b0, lower};
  assign x_down = QUARTER - x_up;

  // 255 * x as (x << 8) - x
  assign p_up     = {x_up, 8'd0} - PR_W'(x_up);
  assign p_down   = {x_down, 8'd0} - PR_W'(x_down);
  assign lvl_up   = p_up[SEG_W +: 8];
  assign lvl_down = p_down[SEG_W +: 8];

  assign p_grey = {frac_i, 8'd0} - GR_W'(frac_i);
  assign grey   = p_grey[T_FRAC_BITS +: 8];

  assign pal_idx = arcm_pkg::tree_index(tree_id_i[14:0]);

  always_comb begin
    if (frac_i[T_FRAC_BITS]) begin
      ramp = '{red: 8'd255, green: 8'd0, blue: 8'd0};
    end else begin
      case (seg)
        2'd0:    ramp = '{red: 8'd0,   green: lvl_up,   blue: 8'd255};
        2'd1:    ramp = '{red: 8'd0,   green: 8'd255,   blue: lvl_down};
        2'd2:    ramp = '{red: lvl_up, green: 8'd255,   blue: 8'd0};
        default: ramp = '{red: 8'd255, green: lvl_down, blue: 8'd0};
      endcase
    end
  end

  always_comb begin
    case (mode_i)
      arcm_pkg::MODE_HEIGHT: rgb_o = ramp;
      arcm_pkg::MODE_TREE: begin
        if (tree_id_i[15]) begin
          rgb_o = '{red: 8'd128, green: 8'd128, blue: 8'd128};
        end else begin
          rgb_o = arcm_pkg::PALETTE[pal_idx];
        end
      end
      arcm_pkg::MODE_LABEL: rgb_o = arcm_pkg::label_color(class_label_i);
      default:              rgb_o = '{red: grey, green: grey, blue: grey};
    endcase
  end

endmodule

FILE: sv/auto_range_false_color_mapper.sv
// ----------------------------------------------------------------------------
// auto_range_false_color_mapper
// Colors point beats by height ramp, tree palette, class table or grey level,
// normalizing height and intensity against a running min/max range.
// Scan beats are done at accept. A height or intensity color beat inside the range
// passes through accept, the divider steps and output load; other color beats
// go straight from accept to output load. The result sits in an output
// register; while it is held the next color beat waits at output load.
// Reset: mode height ramp, range empty (low at max, high at min), no result.
// ----------------------------------------------------------------------------
module auto_range_false_color_mapper #(
  parameter int unsigned T_FRAC_BITS = arcm_pkg::T_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,        // color_mode
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,    // height, intensity, tree_id, class_label
  input  logic [1:0]  s_axis_tuser_i,    // req_type, first_of_cloud
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o     // red, green, blue
);

  localparam int unsigned W = arcm_pkg::VAL_W;
  localparam logic signed [W:0] UNIT_HEIGHT = (W+1)'(256);
  localparam logic signed [W:0] UNIT_INTENS = (W+1)'(1);
  localparam logic [T_FRAC_BITS:0] FRAC_ONE = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;

  arcm_pkg::state_e state_q, state_d;

  logic [1:0]             mode_q;
  logic signed [W-1:0]    low_q, low_d;
  logic signed [W-1:0]    high_q, high_d;
  logic [T_FRAC_BITS:0]   frac_q, frac_d;
  logic [15:0]            tid_q, tid_d;
  logic [7:0]             lab_q, lab_d;
  logic                   out_vld_q, out_vld_d;
  logic [23:0]            out_q, out_d;

  logic                   in_beat;
  logic                   req_type;
  logic                   first_of_cloud;
  logic signed [W-1:0]    height;
  logic [15:0]            intensity;
  logic signed [W-1:0]    val;
  logic signed [W:0]      diff;
  logic signed [W:0]      span_raw;
  logic signed [W:0]      span;
  logic                   div_start;
  logic                   div_done;
  logic [T_FRAC_BITS-1:0] div_quo;
  arcm_pkg::rgb_t         rgb;

  assign req_type       = s_axis_tuser_i[0];
  assign first_of_cloud = s_axis_tuser_i[1];
  assign height         = s_axis_tdata_i[23:0];
  assign intensity      = s_axis_tdata_i[39:24];

  assign s_axis_tready_o = (state_q == arcm_pkg::ST_IDLE);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  assign val      = (mode_q == arcm_pkg::MODE_HEIGHT) ? height : {8'd0, intensity};
  assign diff     = {val[W-1], val} - {low_q[W-1], low_q};
  assign span_raw = {high_q[W-1], high_q} - {low_q[W-1], low_q};

  always_comb begin
    if (span_raw <= 0) begin
      span = (mode_q == arcm_pkg::MODE_HEIGHT) ? UNIT_HEIGHT : UNIT_INTENS;
    end else begin
      span = span_raw;
    end
  end

  arcm_div #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff[W-1:0]),
    .divisor_i  (span[W-1:0]),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  arcm_color #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_color (
    .mode_i        (mode_q),
    .frac_i        (frac_q),
    .tree_id_i     (tid_q),
    .class_label_i (lab_q),
    .rgb_o         (rgb)
  );

  always_comb begin
    state_d   = state_q;
    low_d     = low_q;
    high_d    = high_q;
    frac_d    = frac_q;
    tid_d     = tid_q;
    lab_d     = lab_q;
    out_vld_d = out_vld_q && !m_axis_tready_i;
    out_d     = out_q;
    div_start = 1'b0;
    case (state_q)
      arcm_pkg::ST_IDLE: begin
        if (in_beat) begin
          tid_d = s_axis_tdata_i[55:40];
          lab_d = s_axis_tdata_i[63:56];
          if (req_type == arcm_pkg::REQ_SCAN) begin
            if (mode_q == arcm_pkg::MODE_HEIGHT || mode_q == arcm_pkg::MODE_INTENSITY) begin
              if (first_of_cloud) begin
                low_d  = val;
                high_d = val;
              end else begin
                if (val < low_q) begin
                  low_d = val;
                end
                if (val > high_q) begin
                  high_d = val;
                end
              end
            end
          end else begin
            state_d = arcm_pkg::ST_EMIT;
            if (mode_q == arcm_pkg::MODE_HEIGHT || mode_q == arcm_pkg::MODE_INTENSITY) begin
              if (diff <= 0) begin
                frac_d = '0;
              end else if (diff >= span) begin
                frac_d = FRAC_ONE;
              end else begin
                div_start = 1'b1;
                state_d   = arcm_pkg::ST_DIV;
              end
            end
          end
        end
      end
      arcm_pkg::ST_DIV: begin
        if (div_done) begin
          frac_d  = {1'b0, div_quo};
          state_d = arcm_pkg::ST_EMIT;
        end
      end
      arcm_pkg::ST_EMIT: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d = 1'b1;
          out_d     = rgb;
          state_d   = arcm_pkg::ST_IDLE;
        end
      end
      default: state_d = arcm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= arcm_pkg::ST_IDLE;
      mode_q    <= arcm_pkg::MODE_HEIGHT;
      low_q     <= {1'b0, {(W-1){1'b1}}};
      high_q    <= {1'b1, {(W-1){1'b0}}};
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      low_q     <= low_d;
      high_q    <= high_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    frac_q <= frac_d;
    tid_q  <= tid_d;
    lab_q  <= lab_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

endmodule
